>>> hw/rtl/adl_pkg.sv
package adl_pkg;

    // Sizes of the slot store
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int LINK_W     = SLOT_W + 1;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int OP_W     = 2;
    localparam int IN_SLOT_W = 6;
    localparam int IN_DATA_W = 32;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 7;
    localparam int OUT_DATA_W = 32;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [LINK_W-1:0]     link_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [OP_W-1:0]       op_t;
    typedef logic [STATUS_W-1:0]   status_t;

    // Opcodes
    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_READ   = 2'd2;

    // Status codes
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_NOT_USED = 2'd2;

    // Link value for "no slot"
    localparam link_t LINK_NIL = '1;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic link;
        logic respond;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_link;
        logic out_free;
    } stat_t;

    // A link names a slot when its sign bit is clear
    function automatic logic link_valid(input link_t l);
        return !l[LINK_W-1];
    endfunction

    // Free chain order after reset: slot i points to i+1, the last slot to nil
    function automatic link_t reset_link(input slot_t s);
        int nxt;
        nxt = int'(s) + 1;
        return (nxt < CAPACITY) ? link_t'(nxt) : LINK_NIL;
    endfunction

endpackage

>>> hw/rtl/adl_ctrl.sv
module adl_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  adl_pkg::stat_t stat,
    output adl_pkg::cmd_t  cmd
);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_UPDATE,
        S_LINK,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new item only when no operation is in flight
    assign in_stall = (state_reg != S_IDLE);

    // Issue datapath commands from the current state
    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.update  = (state_reg == S_UPDATE);
        cmd.link    = (state_reg == S_LINK);
        cmd.respond = (state_reg == S_RESP) && stat.out_free;
    end

    // Advance through read, update, second link write (insert and remove) and result
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = stat.needs_link ? S_LINK : S_RESP;
            end
            S_LINK:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/adl_datapath.sv
module adl_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  adl_pkg::cmd_t                     cmd,
    output adl_pkg::stat_t                    stat,
    input  logic [adl_pkg::OP_W-1:0]          opcode,
    input  logic [adl_pkg::IN_SLOT_W-1:0]     slot,
    input  logic [adl_pkg::IN_DATA_W-1:0]     item_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [adl_pkg::STATUS_W-1:0]      status,
    output logic signed [adl_pkg::OUT_W-1:0]  slot_out,
    output logic [adl_pkg::OUT_DATA_W-1:0]    data_out,
    output logic signed [adl_pkg::OUT_W-1:0]  next_out,
    output logic signed [adl_pkg::OUT_W-1:0]  prev_out,
    output logic signed [adl_pkg::OUT_W-1:0]  first_out,
    output logic signed [adl_pkg::OUT_W-1:0]  last_out,
    output logic [adl_pkg::OUT_W-1:0]         count_out
);

    // Link and data memories
    adl_pkg::link_t nl_mem [adl_pkg::CAPACITY];
    adl_pkg::link_t pl_mem [adl_pkg::CAPACITY];
    adl_pkg::word_t dat_mem [adl_pkg::CAPACITY];

    // Next-link entries written since reset; others read as the reset chain
    logic [adl_pkg::CAPACITY-1:0] nl_init_reg;
    logic [adl_pkg::CAPACITY-1:0] in_use_reg;

    // Registered read data
    adl_pkg::link_t nl_q;
    logic           nl_q_init;
    adl_pkg::link_t pl_q;
    adl_pkg::word_t dat_q;
    adl_pkg::link_t nl_rd;

    // Captured item
    adl_pkg::op_t   op_reg;
    adl_pkg::slot_t slot_reg;
    adl_pkg::word_t data_reg;
    adl_pkg::slot_t rd_addr;

    // List state
    adl_pkg::link_t  head_reg;
    adl_pkg::link_t  tail_reg;
    adl_pkg::link_t  free_head_reg;
    adl_pkg::count_t count_reg;

    // Per-item results
    adl_pkg::status_t res_status_reg;
    adl_pkg::link_t   res_slot_reg;
    adl_pkg::word_t   res_data_reg;
    adl_pkg::link_t   res_next_reg;
    adl_pkg::link_t   res_prev_reg;

    // Output register
    logic out_valid_reg;

    logic           op_ok;
    adl_pkg::link_t slot_link;
    logic           nl_we;
    adl_pkg::slot_t nl_wa;
    adl_pkg::link_t nl_wd;
    logic           pl_we;
    adl_pkg::slot_t pl_wa;
    adl_pkg::link_t pl_wd;
    logic           dat_we;

    assign slot_link = adl_pkg::link_t'(slot_reg);
    assign nl_rd     = nl_q_init ? nl_q : adl_pkg::reset_link(slot_reg);

    // Insert reads at the free head, remove and read at the given slot
    assign rd_addr = (opcode == adl_pkg::OP_INSERT) ?
                     free_head_reg[adl_pkg::SLOT_W-1:0] : adl_pkg::slot_t'(slot);

    // Decide whether the operation proceeds
    always_comb
    begin
        case (op_reg)
            adl_pkg::OP_INSERT: op_ok = adl_pkg::link_valid(free_head_reg);
            adl_pkg::OP_REMOVE: op_ok = in_use_reg[slot_reg];
            adl_pkg::OP_READ:   op_ok = in_use_reg[slot_reg];
            default:            op_ok = 1'b1;
        endcase
    end

    assign stat.needs_link = op_ok &&
                             (op_reg == adl_pkg::OP_INSERT || op_reg == adl_pkg::OP_REMOVE);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // Write ports: neighbor links on update, plus own prev link and data on insert; own next link on link step
    always_comb
    begin
        nl_we  = 1'b0;
        nl_wa  = slot_reg;
        nl_wd  = adl_pkg::LINK_NIL;
        pl_we  = 1'b0;
        pl_wa  = slot_reg;
        pl_wd  = tail_reg;
        dat_we = 1'b0;
        if (cmd.update && op_ok && op_reg == adl_pkg::OP_INSERT)
        begin
            nl_we  = adl_pkg::link_valid(tail_reg);
            nl_wa  = tail_reg[adl_pkg::SLOT_W-1:0];
            nl_wd  = slot_link;
            pl_we  = 1'b1;
            dat_we = 1'b1;
        end
        else if (cmd.update && op_ok && op_reg == adl_pkg::OP_REMOVE)
        begin
            nl_we = adl_pkg::link_valid(pl_q);
            nl_wa = pl_q[adl_pkg::SLOT_W-1:0];
            nl_wd = nl_rd;
            pl_we = adl_pkg::link_valid(nl_rd);
            pl_wa = nl_rd[adl_pkg::SLOT_W-1:0];
            pl_wd = pl_q;
        end
        else if (cmd.link && op_reg == adl_pkg::OP_INSERT)
        begin
            nl_we = 1'b1;
            nl_wd = adl_pkg::LINK_NIL;
        end
        else if (cmd.link && op_reg == adl_pkg::OP_REMOVE)
        begin
            nl_we = 1'b1;
            nl_wd = free_head_reg;
        end
    end

    // Memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (nl_we)
        begin
            nl_mem[nl_wa] <= nl_wd;
        end
        if (pl_we)
        begin
            pl_mem[pl_wa] <= pl_wd;
        end
        if (dat_we)
        begin
            dat_mem[slot_reg] <= data_reg;
        end
        if (cmd.capture)
        begin
            nl_q  <= nl_mem[rd_addr];
            pl_q  <= pl_mem[rd_addr];
            dat_q <= dat_mem[rd_addr];
        end
    end

    // Written marks for next links and in-use flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_init_reg <= '0;
            nl_q_init   <= 1'b0;
            in_use_reg  <= '0;
        end
        else
        begin
            if (nl_we)
            begin
                nl_init_reg[nl_wa] <= 1'b1;
            end
            if (cmd.capture)
            begin
                nl_q_init <= nl_init_reg[rd_addr];
            end
            if (cmd.update && op_ok && op_reg == adl_pkg::OP_INSERT)
            begin
                in_use_reg[slot_reg] <= 1'b1;
            end
            else if (cmd.update && op_ok && op_reg == adl_pkg::OP_REMOVE)
            begin
                in_use_reg[slot_reg] <= 1'b0;
            end
        end
    end

    // Capture the item and form the results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            slot_reg <= rd_addr;
            data_reg <= adl_pkg::word_t'(item_data);
        end
        if (cmd.update)
        begin
            res_status_reg <= adl_pkg::ST_OK;
            res_slot_reg   <= adl_pkg::LINK_NIL;
            res_data_reg   <= '0;
            res_next_reg   <= adl_pkg::LINK_NIL;
            res_prev_reg   <= adl_pkg::LINK_NIL;
            if (!op_ok)
            begin
                res_status_reg <= (op_reg == adl_pkg::OP_INSERT) ?
                                  adl_pkg::ST_FULL : adl_pkg::ST_NOT_USED;
            end
            else if (op_reg == adl_pkg::OP_INSERT)
            begin
                res_slot_reg <= slot_link;
            end
            else if (op_reg == adl_pkg::OP_READ)
            begin
                res_data_reg <= dat_q;
                res_next_reg <= nl_rd;
                res_prev_reg <= pl_q;
            end
        end
    end

    // List head, tail, free head and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= adl_pkg::LINK_NIL;
            tail_reg      <= adl_pkg::LINK_NIL;
            free_head_reg <= '0;
            count_reg     <= '0;
        end
        else if (cmd.update && op_ok && op_reg == adl_pkg::OP_INSERT)
        begin
            free_head_reg <= nl_rd;
            tail_reg      <= slot_link;
            count_reg     <= count_reg + adl_pkg::count_t'(1);
            if (!adl_pkg::link_valid(tail_reg))
            begin
                head_reg <= slot_link;
            end
        end
        else if (cmd.update && op_ok && op_reg == adl_pkg::OP_REMOVE)
        begin
            count_reg <= count_reg - adl_pkg::count_t'(1);
            if (!adl_pkg::link_valid(pl_q))
            begin
                head_reg <= nl_rd;
            end
            if (!adl_pkg::link_valid(nl_rd))
            begin
                tail_reg <= pl_q;
            end
        end
        else if (cmd.link && op_reg == adl_pkg::OP_REMOVE)
        begin
            free_head_reg <= slot_link;
        end
    end

    // Output valid: set on load, drop after transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.respond)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            status    <= res_status_reg;
            slot_out  <= adl_pkg::OUT_W'(res_slot_reg);
            data_out  <= adl_pkg::OUT_DATA_W'(res_data_reg);
            next_out  <= adl_pkg::OUT_W'(res_next_reg);
            prev_out  <= adl_pkg::OUT_W'(res_prev_reg);
            first_out <= adl_pkg::OUT_W'(head_reg);
            last_out  <= adl_pkg::OUT_W'(tail_reg);
            count_out <= adl_pkg::OUT_W'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/array_doubly_linked_list.sv
// Insert and remove pass through the update, link and result states after the
// input transfer; read, full, not-in-use and unknown operations skip the link
// state. A new item waits until the last result is loaded for output; the link
// state is needed by the single write port of the next-link memory, which an
// insert or remove uses twice. Reset (rst_n, async, active low): list empty,
// free chain 0..63 in order, available at once after reset, no clearing pass.
module array_doubly_linked_list
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [adl_pkg::OP_W-1:0]          opcode,
    input  logic [adl_pkg::IN_SLOT_W-1:0]     slot,
    input  logic [adl_pkg::IN_DATA_W-1:0]     item_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [adl_pkg::STATUS_W-1:0]      status,
    output logic signed [adl_pkg::OUT_W-1:0]  slot_out,
    output logic [adl_pkg::OUT_DATA_W-1:0]    data_out,
    output logic signed [adl_pkg::OUT_W-1:0]  next_out,
    output logic signed [adl_pkg::OUT_W-1:0]  prev_out,
    output logic signed [adl_pkg::OUT_W-1:0]  first_out,
    output logic signed [adl_pkg::OUT_W-1:0]  last_out,
    output logic [adl_pkg::OUT_W-1:0]         count_out
);

    adl_pkg::cmd_t  cmd;
    adl_pkg::stat_t stat;

    adl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    adl_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .opcode    (opcode),
        .slot      (slot),
        .item_data (item_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .slot_out  (slot_out),
        .data_out  (data_out),
        .next_out  (next_out),
        .prev_out  (prev_out),
        .first_out (first_out),
        .last_out  (last_out),
        .count_out (count_out)
    );

endmodule

>>> hw/rtl/adl_checker.sv
module adl_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [adl_pkg::STATUS_W-1:0]     status,
    input logic [adl_pkg::OUT_W-1:0]        slot_out,
    input logic [adl_pkg::OUT_W-1:0]        first_out,
    input logic [adl_pkg::OUT_W-1:0]        last_out,
    input logic [adl_pkg::OUT_W-1:0]        count_out
);

    localparam logic [adl_pkg::OUT_W-1:0] NIL7 = '1;

    // Hold a stalled result until transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Full is reported only with every slot in use
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == adl_pkg::ST_FULL |->
        count_out == adl_pkg::OUT_W'(adl_pkg::CAPACITY))
        else $error("full reported with free slots");

    // Empty list has no head or tail
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_out == '0 |-> first_out == NIL7 && last_out == NIL7)
        else $error("empty list shows an end slot");

    // An inserted slot becomes the tail
    a_insert_tail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slot_out != NIL7 |-> slot_out == last_out && count_out != '0)
        else $error("inserted slot is not the tail");

endmodule

bind array_doubly_linked_list adl_checker u_adl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .slot_out  (slot_out),
    .first_out (first_out),
    .last_out  (last_out),
    .count_out (count_out)
);
